// ----- rtl/core/static_target_classifier_macros.svh -----
// assertion helpers shared by the rtl
`ifndef STATIC_TARGET_CLASSIFIER_MACROS_SVH
`define STATIC_TARGET_CLASSIFIER_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define STC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("static_target_classifier assertion failed");

// condition must never be true outside reset
`define STC_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("static_target_classifier forbidden condition seen");

`endif

// ----- rtl/core/stc_pkg.sv -----
`timescale 1ns / 1ps

package stc_pkg;

   localparam int TABLE_ENTRIES = 32;
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int THR_W = 15;
   localparam int FRAMES_W = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STATIC_FRAMES = 2'd1;

   localparam logic [THR_W-1:0] SPEED_THRESHOLD_RESET = 15'd128;
   localparam logic [FRAMES_W-1:0] STATIC_FRAMES_RESET = 8'd20;

   localparam logic [1:0] OP_CLASSIFY = 2'd0;
   localparam logic [1:0] OP_MARK = 2'd1;
   localparam logic [1:0] OP_SWEEP = 2'd2;

   localparam logic [7:0] COUNT_MAX = 8'hFF;

   typedef struct packed {
      logic [1:0] op;
      logic [15:0] id;
      logic slow;
   } stc_item_type;

endpackage

// ----- rtl/core/stc_front.sv -----
`timescale 1ns / 1ps

module stc_front import stc_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic [THR_W-1:0] speed_threshold,
   input  logic req_valid,
   output logic req_ready,
   input  logic [1:0] req_operation,
   input  logic [15:0] req_track_id,
   input  logic signed [15:0] req_vel_x,
   input  logic signed [15:0] req_vel_y,
   output logic push_valid,
   input  logic push_ready,
   output stc_item_type push_item
);

   logic s1_valid_ff, s1_valid_in;
   logic [1:0] s1_op_ff;
   logic [15:0] s1_id_ff;
   logic [30:0] s1_sqx_ff, s1_sqy_ff;
   logic [2*THR_W-1:0] thr_sq_ff;
   logic s2_valid_ff, s2_valid_in;
   stc_item_type s2_item_ff, s2_item_in;
   logic s1_load, s2_load;
   logic signed [31:0] prod_x, prod_y;
   logic [31:0] sq_sum;

   assign s2_load = s1_valid_ff && (!s2_valid_ff || push_ready);
   assign req_ready = !s1_valid_ff || s2_load;
   assign s1_load = req_valid && req_ready;

   assign prod_x = req_vel_x * req_vel_x;
   assign prod_y = req_vel_y * req_vel_y;

   // squares are at most 2^30 each, so the sum fits in 32 bits
   assign sq_sum = {1'b0, s1_sqx_ff} + {1'b0, s1_sqy_ff};

   always_comb begin
      s2_item_in.op = s1_op_ff;
      s2_item_in.id = s1_id_ff;
      s2_item_in.slow = sq_sum < {2'b00, thr_sq_ff};
   end

   always_comb begin
      if (s1_load) begin
         s1_valid_in = 1'b1;
      end else if (s2_load) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (s2_load) begin
         s2_valid_in = 1'b1;
      end else if (push_ready) begin
         s2_valid_in = 1'b0;
      end else begin
         s2_valid_in = s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      thr_sq_ff <= speed_threshold * speed_threshold;
      if (s1_load) begin
         s1_op_ff <= req_operation;
         s1_id_ff <= req_track_id;
         s1_sqx_ff <= prod_x[30:0];
         s1_sqy_ff <= prod_y[30:0];
      end
      if (s2_load) begin
         s2_item_ff <= s2_item_in;
      end
   end

   assign push_valid = s2_valid_ff;
   assign push_item = s2_item_ff;

endmodule

// ----- rtl/core/stc_queue.sv -----
`timescale 1ns / 1ps

module stc_queue import stc_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic push_valid,
   output logic push_ready,
   input  stc_item_type push_item,
   output logic pop_valid,
   input  logic pop_ready,
   output stc_item_type pop_item
);

   stc_item_type slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic push, pop;

   assign push_ready = count_ff != QCNT_W'(QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign push = push_valid && push_ready;
   assign pop = pop_valid && pop_ready;
   assign pop_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- rtl/core/stc_table.sv -----
`timescale 1ns / 1ps
`include "static_target_classifier_macros.svh"

module stc_table import stc_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic [FRAMES_W-1:0] static_frames,
   input  logic pop_valid,
   output logic pop_ready,
   input  stc_item_type pop_item,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic rsp_is_static,
   output logic rsp_table_full
);

   localparam logic ST_LOOK = 1'b0;
   localparam logic ST_UPD = 1'b1;

   logic state_ff, state_in;
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [TABLE_ENTRIES-1:0] seen_ff, seen_in;
   logic [15:0] track_ff [TABLE_ENTRIES];
   logic [7:0] count_ff [TABLE_ENTRIES];

   stc_item_type item_ff;
   logic hit_ff, hit_in;
   logic free_ff, free_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic [TABLE_ENTRIES-1:0] match;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_static_ff, rsp_full_ff;

   logic is_classify, go, apply, full, alloc, count_wr;
   logic [IDX_W-1:0] idx;
   logic [7:0] cur_count, new_count;
   logic at_limit;

   // lookup: parallel compare, lowest match and lowest free entry
   always_comb begin
      hit_in = 1'b0;
      free_in = 1'b0;
      hit_idx_in = '0;
      free_idx_in = '0;
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         match[i] = valid_ff[i] && (track_ff[i] == pop_item.id);
         if (match[i]) begin
            hit_in = 1'b1;
            hit_idx_in = IDX_W'(i);
         end
         if (!valid_ff[i]) begin
            free_in = 1'b1;
            free_idx_in = IDX_W'(i);
         end
      end
   end

   assign pop_ready = (state_ff == ST_LOOK);

   // update step
   assign is_classify = item_ff.op == OP_CLASSIFY;
   assign go = !is_classify || !rsp_valid_ff || rsp_ready;
   assign apply = (state_ff == ST_UPD) && go;
   assign full = !hit_ff && !free_ff;
   assign idx = hit_ff ? hit_idx_ff : free_idx_ff;
   assign cur_count = hit_ff ? count_ff[hit_idx_ff] : 8'd0;
   assign alloc = apply && is_classify && !hit_ff && free_ff;
   assign count_wr = apply && is_classify && !full;

   always_comb begin
      if (!item_ff.slow) begin
         new_count = 8'd0;
      end else if (cur_count == COUNT_MAX) begin
         new_count = COUNT_MAX;
      end else begin
         new_count = cur_count + 8'd1;
      end
   end

   assign at_limit = new_count >= static_frames;

   always_comb begin
      valid_in = valid_ff;
      seen_in = seen_ff;
      if (alloc) begin
         valid_in[idx] = 1'b1;
         seen_in[idx] = 1'b0;
      end
      if (apply && item_ff.op == OP_MARK && hit_ff) begin
         seen_in[hit_idx_ff] = 1'b1;
      end
      if (apply && item_ff.op == OP_SWEEP) begin
         valid_in = valid_ff & seen_ff;
         seen_in = '0;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOOK: begin
            if (pop_valid) begin
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            if (go) begin
               state_in = ST_LOOK;
            end
         end
         default: state_in = ST_LOOK;
      endcase
   end

   always_comb begin
      if (apply && is_classify) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOOK;
         valid_ff <= '0;
         seen_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         seen_ff <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_valid && pop_ready) begin
         item_ff <= pop_item;
         hit_ff <= hit_in;
         free_ff <= free_in;
         hit_idx_ff <= hit_idx_in;
         free_idx_ff <= free_idx_in;
      end
      if (alloc) begin
         track_ff[idx] <= item_ff.id;
      end
      if (count_wr) begin
         count_ff[idx] <= new_count;
      end
      if (apply && is_classify) begin
         rsp_static_ff <= !full && at_limit;
         rsp_full_ff <= full;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_is_static = rsp_static_ff;
   assign rsp_table_full = rsp_full_ff;

   // an id lives in at most one entry
   `STC_ASSERT(a_unique_id, clock, reset, !pop_valid || $onehot0(match))
   // a mark only sits on a live entry
   `STC_ASSERT_NEVER(a_seen_without_valid, clock, reset, (seen_ff & ~valid_ff) != '0)
   // a sweep leaves no marks behind
   `STC_ASSERT(a_sweep_clears, clock, reset, apply && item_ff.op == OP_SWEEP |=> seen_ff == '0)
   // a full answer only when every entry was taken
   `STC_ASSERT(a_full_means_taken, clock, reset, apply && is_classify && full |=> &valid_ff)

endmodule

// ----- rtl/core/static_target_classifier.sv -----
`timescale 1ns / 1ps

// static target classifier
// req channel: one transaction per track item (classify, mark live, sweep).
//   code 3 is dropped without effect. only classify produces a rsp transaction.
// rsp channel: static flag and table_full for each classify, in request order.
// csr channel: index 0 speed threshold (1/256 m/s), index 1 static frame count.
//   csr_ready is always high; write only while no transaction is in flight.
// path of a classify answer to rsp when nothing stalls: square and compare
//   stages, queue slot, table lookup state, update state and result register.
// the table's lookup/update sequencer takes a new item only after the update of
//   the last; the front and its two-entry queue keep accepting meanwhile.
// the table holds TABLE_ENTRIES track entries compared in parallel.
// reset: entries all free, marks cleared, registers back to 128 and 20.
// rsp stall: the result register holds; mark and sweep transactions keep
//   draining, a second classify waits in the table and then the queue and front
//   fill until req_ready drops.

module static_target_classifier import stc_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [1:0] req_operation,
   input  logic [15:0] req_track_id,
   input  logic signed [15:0] req_vel_x,
   input  logic signed [15:0] req_vel_y,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic rsp_is_static,
   output logic rsp_table_full,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic [THR_W-1:0] speed_threshold_ff, speed_threshold_in;
   logic [FRAMES_W-1:0] static_frames_ff, static_frames_in;
   logic push_valid, push_ready, pop_valid, pop_ready;
   stc_item_type push_item, pop_item;

   assign csr_ready = 1'b1;

   always_comb begin
      speed_threshold_in = speed_threshold_ff;
      static_frames_in = static_frames_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SPEED_THRESHOLD: speed_threshold_in = csr_data[THR_W-1:0];
            CSR_STATIC_FRAMES: static_frames_in = csr_data[FRAMES_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_threshold_ff <= SPEED_THRESHOLD_RESET;
         static_frames_ff <= STATIC_FRAMES_RESET;
      end else begin
         speed_threshold_ff <= speed_threshold_in;
         static_frames_ff <= static_frames_in;
      end
   end

   stc_front u_front (
      .clock(clock),
      .reset(reset),
      .speed_threshold(speed_threshold_ff),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_operation(req_operation),
      .req_track_id(req_track_id),
      .req_vel_x(req_vel_x),
      .req_vel_y(req_vel_y),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_item(push_item)
   );

   stc_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_item(push_item),
      .pop_valid(pop_valid),
      .pop_ready(pop_ready),
      .pop_item(pop_item)
   );

   stc_table u_table (
      .clock(clock),
      .reset(reset),
      .static_frames(static_frames_ff),
      .pop_valid(pop_valid),
      .pop_ready(pop_ready),
      .pop_item(pop_item),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_is_static(rsp_is_static),
      .rsp_table_full(rsp_table_full)
   );

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
   import stc_pkg::*;

   // operation code 3 is defined as a no-op but has no name in the package
   localparam logic [1:0] OP_NOP = 2'd3;
   localparam int QUIET_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 12;

   typedef struct packed {
      logic [1:0] op;
      logic [15:0] id;
      logic signed [15:0] vx;
      logic signed [15:0] vy;
   } track_req_t;

   typedef struct packed {
      logic at_rest;
      logic table_full;
   } verdict_t;

   typedef enum bit {ROW_TXN, ROW_CSR} row_kind_e;

   // code is the operation or the register index, word the track id or write data
   typedef struct {
      row_kind_e kind;
      int code;
      int word;
      int vx;
      int vy;
      bit typed;
      bit st;
      bit full;
   } dir_row_t;

   dir_row_t dir_table [26] = '{
      '{ROW_TXN, OP_CLASSIFY, 'h0000, 0, 0, 1'b1, 1'b0, 1'b0},
      '{ROW_TXN, OP_CLASSIFY, 'hFFFF, -32768, -32768, 1'b1, 1'b0, 1'b0},
      '{ROW_TXN, OP_CLASSIFY, 'hFFFF, 32767, 32767, 1'b1, 1'b0, 1'b0},
      '{ROW_TXN, OP_CLASSIFY, 'h0000, 127, 0, 1'b0, 1'b0, 1'b0},
      '{ROW_TXN, OP_CLASSIFY, 'h0000, 0, -128, 1'b0, 1'b0, 1'b0},
      '{ROW_TXN, OP_MARK, 'h0000, 0, 0, 1'b0, 1'b0, 1'b0},
      '{ROW_TXN, OP_MARK, 'h1234, 0, 0, 1'b0, 1'b0, 1'b0},
      '{ROW_TXN, OP_NOP, 'hFFFF, -1, -1, 1'b0, 1'b0, 1'b0},
      '{ROW_TXN, OP_SWEEP, 'hFFFF, 0, 0, 1'b0, 1'b0, 1'b0},
      '{ROW_TXN, OP_CLASSIFY, 'h5A5A, 0, 0, 1'b0, 1'b0, 1'b0},
      '{ROW_TXN, OP_CLASSIFY, 'hFFFF, 0, 0, 1'b0, 1'b0, 1'b0},
      '{ROW_CSR, CSR_STATIC_FRAMES, 1, 0, 0, 1'b0, 1'b0, 1'b0},
      '{ROW_TXN, OP_CLASSIFY, 'h0001, 1, -1, 1'b1, 1'b1, 1'b0},
      '{ROW_TXN, OP_CLASSIFY, 'h0000, -1, 0, 1'b1, 1'b1, 1'b0},
      '{ROW_CSR, CSR_STATIC_FRAMES, 0, 0, 0, 1'b0, 1'b0, 1'b0},
      '{ROW_TXN, OP_CLASSIFY, 'h0002, 32767, -32768, 1'b1, 1'b1, 1'b0},
      '{ROW_CSR, CSR_SPEED_THRESHOLD, 0, 0, 0, 1'b0, 1'b0, 1'b0},
      '{ROW_CSR, CSR_STATIC_FRAMES, 255, 0, 0, 1'b0, 1'b0, 1'b0},
      '{ROW_TXN, OP_CLASSIFY, 'h0001, 0, 0, 1'b1, 1'b0, 1'b0},
      '{ROW_CSR, CSR_SPEED_THRESHOLD, 'hFFFF, 0, 0, 1'b0, 1'b0, 1'b0},
      '{ROW_TXN, OP_CLASSIFY, 'h0002, 23169, -23169, 1'b0, 1'b0, 1'b0},
      '{ROW_TXN, OP_CLASSIFY, 'h0002, -23170, 23170, 1'b0, 1'b0, 1'b0},
      '{ROW_TXN, OP_CLASSIFY, 'h0003, 32767, 0, 1'b0, 1'b0, 1'b0},
      '{ROW_TXN, OP_SWEEP, 'h0000, 0, 0, 1'b0, 1'b0, 1'b0},
      '{ROW_TXN, OP_MARK, 'h0001, 0, 0, 1'b0, 1'b0, 1'b0},
      '{ROW_TXN, OP_CLASSIFY, 'h0001, 0, 0, 1'b0, 1'b0, 1'b0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_operation = OP_NOP;
   logic [15:0] req_track_id = '0;
   logic signed [15:0] req_vel_x = '0;
   logic signed [15:0] req_vel_y = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_is_static;
   logic rsp_table_full;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // shadow of the track table and registers
   logic tbl_valid [TABLE_ENTRIES];
   logic [15:0] tbl_id [TABLE_ENTRIES];
   logic [7:0] tbl_count [TABLE_ENTRIES];
   logic tbl_live [TABLE_ENTRIES];
   logic [THR_W-1:0] thr_reg;
   logic [FRAMES_W-1:0] frames_reg;

   verdict_t pending_verdicts [$];
   int mismatch_count = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_req = 0;
   int hold_left = 0;
   int quiet_cycles = 0;

   static_target_classifier dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_operation(req_operation),
      .req_track_id(req_track_id),
      .req_vel_x(req_vel_x),
      .req_vel_y(req_vel_y),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_is_static(rsp_is_static),
      .rsp_table_full(rsp_table_full),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #4 clock = ~clock;

   function automatic track_req_t make_req(input logic [1:0] op, input logic [15:0] id,
                                           input logic [15:0] vx, input logic [15:0] vy);
      track_req_t t;
      t.op = op;
      t.id = id;
      t.vx = vx;
      t.vy = vy;
      return t;
   endfunction

   function automatic int find_track(input logic [15:0] id);
      int e;
      for (e = TABLE_ENTRIES - 1; e >= 0; e--)
         if (tbl_valid[e] && tbl_id[e] == id) find_track = e;
      // lowest matching entry wins
      if (find_track === 0 && !(tbl_valid[0] && tbl_id[0] == id)) find_track = -1;
   endfunction

   // applies one item to the shadow table, returns 1 when it yields a verdict
   function automatic bit track_table_step(input track_req_t t, output verdict_t v);
      int hit;
      int e;
      longint speed_sq;
      longint limit_sq;
      v = '0;
      case (t.op)
         OP_CLASSIFY: begin
            hit = find_track(t.id);
            if (hit < 0) begin
               for (e = TABLE_ENTRIES - 1; e >= 0; e--)
                  if (!tbl_valid[e]) hit = e;
               if (hit < 0) begin
                  v.table_full = 1'b1;
                  return 1'b1;
               end
               tbl_valid[hit] = 1'b1;
               tbl_id[hit] = t.id;
               tbl_count[hit] = '0;
               tbl_live[hit] = 1'b0;
            end
            speed_sq = longint'($signed(t.vx)) * longint'($signed(t.vx)) +
                       longint'($signed(t.vy)) * longint'($signed(t.vy));
            limit_sq = longint'(thr_reg) * longint'(thr_reg);
            if (speed_sq < limit_sq) begin
               if (tbl_count[hit] != COUNT_MAX) tbl_count[hit] = tbl_count[hit] + 8'd1;
            end else begin
               tbl_count[hit] = '0;
            end
            v.at_rest = (tbl_count[hit] >= frames_reg);
            return 1'b1;
         end
         OP_MARK: begin
            hit = find_track(t.id);
            if (hit >= 0) tbl_live[hit] = 1'b1;
            return 1'b0;
         end
         OP_SWEEP: begin
            for (e = 0; e < TABLE_ENTRIES; e++) begin
               if (tbl_valid[e] && !tbl_live[e]) tbl_valid[e] = 1'b0;
               tbl_live[e] = 1'b0;
            end
            return 1'b0;
         end
         default: return 1'b0;
      endcase
   endfunction

   // mostly slow relative to the current threshold, with some near it and some wild
   function automatic logic [15:0] pick_vel();
      int lim;
      int near_v;
      lim = int'(thr_reg) * 7 / 10;
      near_v = int'(thr_reg) + int'($urandom_range(4)) - 2;
      case ($urandom_range(9))
         0, 1, 2, 3, 4, 5: return (lim == 0) ? 16'd0 : 16'($urandom_range(2 * lim) - lim);
         6: return $urandom_range(1) ? 16'(near_v) : 16'(-near_v);
         7, 8: return 16'($urandom);
         default: begin
            case ($urandom_range(3))
               0: return 16'h8000;
               1: return 16'h7FFF;
               2: return 16'h0000;
               default: return 16'hFFFF;
            endcase
         end
      endcase
   endfunction

   // entered after a posedge or a negedge, returns at the accepting posedge with valid high
   task automatic send_item(input track_req_t t, input bit typed, input verdict_t want);
      verdict_t v;
      @(negedge clock);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_operation <= t.op;
      req_track_id <= t.id;
      req_vel_x <= t.vx;
      req_vel_y <= t.vy;
      do @(posedge clock); while (req_ready !== 1'b1);
      if (track_table_step(t, v)) pending_verdicts.push_back(typed ? want : v);
   endtask

   task automatic settle_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(negedge clock);
      // marks and sweeps may still be in the pipe
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      settle_idle();
      csr_index <= idx;
      csr_data <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (csr_ready !== 1'b1);
      if (idx == CSR_SPEED_THRESHOLD) thr_reg = data[THR_W-1:0];
      else if (idx == CSR_STATIC_FRAMES) frames_reg = data[FRAMES_W-1:0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // tracker-like frames: classify a slice of the live ids, mark most, then sweep in most frames
   task automatic run_traffic(input int n_items, input int pool_n, input int noise_pct);
      logic [15:0] pool [64];
      int sent;
      int m;
      int base;
      int k;
      logic [1:0] nop;
      for (k = 0; k < pool_n; k++) pool[k] = 16'($urandom);
      sent = 0;
      while (sent < n_items) begin
         m = $urandom_range(1, pool_n);
         base = $urandom_range(pool_n - 1);
         for (k = 0; k < m; k++) begin
            if ($urandom_range(99) < noise_pct) begin
               nop = 2'($urandom_range(3));
               send_item(make_req(nop, $urandom_range(1) ? pool[k % pool_n] : 16'($urandom),
                                  16'($urandom), 16'($urandom)), 1'b0, '0);
               if (nop != OP_NOP) sent++;
            end
            send_item(make_req(OP_CLASSIFY, pool[(base + k) % pool_n], pick_vel(),
                               pick_vel()), 1'b0, '0);
            sent++;
         end
         for (k = 0; k < m; k++) begin
            if ($urandom_range(99) < 85) begin
               send_item(make_req(OP_MARK, pool[(base + k) % pool_n], '0, '0), 1'b0, '0);
               sent++;
            end
         end
         if ($urandom_range(9) != 0) begin
            send_item(make_req(OP_SWEEP, 16'($urandom), '0, '0), 1'b0, '0);
            sent++;
         end
         // track turnover
         if ($urandom_range(2) == 0) pool[$urandom_range(pool_n - 1)] = 16'($urandom);
      end
   endtask

   // result side: ready pattern at the falling edge, check at the rising edge
   always @(negedge clock) begin
      if (hold_req > 0) begin
         hold_left = hold_req;
         hold_req = 0;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      verdict_t exp_v;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (pending_verdicts.size() == 0) begin
            $display("%0t: rsp transaction with none expected, actual static=%0b full=%0b",
                     $time, rsp_is_static, rsp_table_full);
            mismatch_count++;
         end else begin
            exp_v = pending_verdicts.pop_front();
            if (rsp_is_static !== exp_v.at_rest) begin
               $display("%0t: static flag expected %0b actual %0b",
                        $time, exp_v.at_rest, rsp_is_static);
               mismatch_count++;
            end
            if (rsp_table_full !== exp_v.table_full) begin
               $display("%0t: table_full expected %0b actual %0b",
                        $time, exp_v.table_full, rsp_table_full);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready) ||
          (csr_valid && csr_ready === 1'b1))
         quiet_cycles = 0;
      else
         quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      int n;
      logic [15:0] sat_id;
      for (n = 0; n < TABLE_ENTRIES; n++) begin
         tbl_valid[n] = 1'b0;
         tbl_live[n] = 1'b0;
      end
      thr_reg = SPEED_THRESHOLD_RESET;
      frames_reg = STATIC_FRAMES_RESET;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_table[r]) begin
         if (dir_table[r].kind == ROW_CSR)
            write_csr(CSR_INDEX_W'(dir_table[r].code), CSR_DATA_W'(dir_table[r].word));
         else
            send_item(make_req(2'(dir_table[r].code), 16'(dir_table[r].word),
                               16'(dir_table[r].vx), 16'(dir_table[r].vy)),
                      dir_table[r].typed, verdict_t'{dir_table[r].st, dir_table[r].full});
      end

      // back-to-back, with the result side held off long enough to back up the input
      write_csr(CSR_SPEED_THRESHOLD, 16'($urandom_range(64, 2048)));
      write_csr(CSR_STATIC_FRAMES, 16'($urandom_range(2, 6)));
      send_idle_pct = 0;
      stall_pct = 0;
      hold_req = 300;
      run_traffic(250, 20, 10);

      // more live ids than entries, so the table runs full
      write_csr(CSR_SPEED_THRESHOLD, 16'($urandom_range(1, 32767)));
      write_csr(CSR_STATIC_FRAMES, 16'($urandom_range(1, 30)));
      send_idle_pct = 71;
      stall_pct = 0;
      run_traffic(250, 48, 10);

      // one long slow track drives the counter into saturation
      write_csr(CSR_SPEED_THRESHOLD, 16'd32767);
      write_csr(CSR_STATIC_FRAMES, 16'd255);
      send_idle_pct = 0;
      stall_pct = 71;
      send_item(make_req(OP_SWEEP, '0, '0, '0), 1'b0, '0);
      send_item(make_req(OP_SWEEP, '0, '0, '0), 1'b0, '0);
      sat_id = 16'($urandom);
      for (n = 0; n < 300; n++) begin
         if ($urandom_range(9) == 0)
            send_item(make_req(OP_MARK, sat_id, '0, '0), 1'b0, '0);
         send_item(make_req(OP_CLASSIFY, sat_id, 16'($urandom_range(40000) - 20000),
                            16'($urandom_range(40000) - 20000)), 1'b0, '0);
      end

      write_csr(CSR_SPEED_THRESHOLD, 16'($urandom_range(0, 600)));
      write_csr(CSR_STATIC_FRAMES, 16'($urandom_range(1, 3)));
      send_idle_pct = 13;
      stall_pct = 13;
      run_traffic(250, 30, 25);

      settle_idle();
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
